>>> rtl/mtlb_pkg.sv
// ----------------------------------------------------------------------------
// mtlb_pkg: shared types and constants
// Payload types, opcodes, register selects and CP0 constants for the
// TLB refill exception entry block.
// ----------------------------------------------------------------------------
package mtlb_pkg;

   localparam int TLB_ENTRIES = 32;
   localparam int RANGE_SLOTS = 64;
   localparam int SCAN_SLOTS  = (2 * TLB_ENTRIES > RANGE_SLOTS) ? RANGE_SLOTS
                                                                : 2 * TLB_ENTRIES;
   localparam int SLOT_W      = $clog2(RANGE_SLOTS);
   localparam int SCAN_CNT_W  = $clog2(RANGE_SLOTS + 1);

   localparam logic [2:0] OP_REFILL_LOAD  = 3'd0;
   localparam logic [2:0] OP_REFILL_STORE = 3'd1;
   localparam logic [2:0] OP_REFILL_FETCH = 3'd2;
   localparam logic [2:0] OP_GENERAL      = 3'd3;
   localparam logic [2:0] OP_WRITE_RANGE  = 3'd4;
   localparam logic [2:0] OP_WRITE_REG    = 3'd5;

   localparam logic [2:0] SEL_STATUS    = 3'd0;
   localparam logic [2:0] SEL_CAUSE     = 3'd1;
   localparam logic [2:0] SEL_EPC       = 3'd2;
   localparam logic [2:0] SEL_BAD_VADDR = 3'd3;
   localparam logic [2:0] SEL_CONTEXT   = 3'd4;
   localparam logic [2:0] SEL_ENTRY_HI  = 3'd5;

   localparam logic [31:0] CTX_KEEP_MASK  = 32'hFF80_000F;
   localparam logic [31:0] CTX_VPN_MASK   = 32'h007F_FFF0;
   localparam logic [31:0] EHI_VPN_MASK   = 32'hFFFF_E000;
   localparam logic [31:0] VEC_GENERAL    = 32'h8000_0180;
   localparam logic [31:0] VEC_REFILL     = 32'h8000_0000;
   localparam logic [31:0] STATUS_EXL     = 32'h0000_0002;
   localparam logic [31:0] CAUSE_TLB_LOAD = 32'h0000_0008;
   localparam logic [31:0] CAUSE_TLB_STOR = 32'h0000_000C;
   localparam logic [1:0]  KSEG0_TOP      = 2'b10;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [31:0] fault_address;
      logic [31:0] current_pc;
      logic        in_delay_slot;
      logic [5:0]  range_slot;
      logic [31:0] range_low;
      logic [31:0] range_high;
      logic [2:0]  reg_select;
      logic [31:0] reg_value;
   } req_type;

   typedef struct packed {
      logic        took_exception;
      logic [31:0] next_pc;
      logic [31:0] status_out;
      logic [31:0] cause_out;
      logic [31:0] epc_out;
      logic [31:0] bad_vaddr_out;
      logic [31:0] context_out;
      logic [31:0] entry_hi_out;
   } rsp_type;

endpackage

>>> rtl/mtlb_ifs.sv
// ----------------------------------------------------------------------------
// mtlb_ifs: request and response channels
// Valid/ready channels carrying the request and response payloads.
// ----------------------------------------------------------------------------
interface mtlb_req_if;
   logic              valid;
   logic              ready;
   mtlb_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface mtlb_rsp_if;
   logic              valid;
   logic              ready;
   mtlb_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/mips_tlb_refill_exception_entry.sv
// ----------------------------------------------------------------------------
// mips_tlb_refill_exception_entry: CP0 exception entry
// Status/Cause/EPC/BadVAddr/Context/EntryHi updates for TLB refill and
// general exceptions, with a mapped-range table scanned for the vector.
//
// Usage:
//  - req_if carries one request per valid/ready handshake: a refill, a
//    general exception, a range-table write or a register write.
//  - rsp_if returns exactly one response per request: exception flag,
//    vector and the six registers after the request.
//  - Most requests go straight from acceptance to the response state. A
//    refill with EXL clear whose address lies outside kseg0 first scans the
//    range table, one slot per cycle through the table's single read port
//    and one shared compare, before its response is built.
//  - One request is in flight at a time; req_if.ready is high only while
//    the sequencer is idle and the response register is empty.
//  - A stalled response holds in its register until taken.
//  - Synchronous reset clears the CP0 registers, the sequencer, the response
//    valid and the table valid bits, so every range slot reads as zero
//    until written. No clearing pass.
// ----------------------------------------------------------------------------
module mips_tlb_refill_exception_entry (
   input  logic              clock,
   input  logic              reset,
   mtlb_req_if.sink          req_if,
   mtlb_rsp_if.source        rsp_if
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [31:0] status_ff, status_in;
   logic [31:0] cause_ff, cause_in;
   logic [31:0] epc_ff, epc_in;
   logic [31:0] badv_ff, badv_in;
   logic [31:0] ctx_ff, ctx_in;
   logic [31:0] ehi_ff, ehi_in;
   logic [31:0] addr_ff, addr_in;
   logic        took_ff, took_in;
   logic [31:0] npc_ff, npc_in;
   logic [mtlb_pkg::SCAN_CNT_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic        issue_ff, issue_in;
   logic        hit_ff, hit_in;
   logic        rsp_valid_ff, rsp_valid_in;
   mtlb_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [63:0] range_mem [mtlb_pkg::RANGE_SLOTS];
   logic [mtlb_pkg::RANGE_SLOTS-1:0] range_vld_ff;
   logic [63:0] rd_data_ff;
   logic        rd_vld_ff;

   mtlb_pkg::req_type req;
   logic        accept;
   logic        exl;
   logic        kseg0;
   logic [31:0] epc_base;
   logic [31:0] epc_dec;
   logic [31:0] rd_start;
   logic [31:0] rd_end;
   logic        slot_hit;
   logic        scan_issue;
   logic [mtlb_pkg::SLOT_W-1:0] scan_idx;

   assign req    = req_if.payload;
   assign accept = req_if.valid && req_if.ready;
   assign req_if.ready  = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   assign exl   = (status_ff & mtlb_pkg::STATUS_EXL) != 32'd0;
   assign kseg0 = req.fault_address[31:30] == mtlb_pkg::KSEG0_TOP;

   assign scan_issue = (state_ff == ST_SCAN) &&
                       (scan_cnt_ff != mtlb_pkg::SCAN_CNT_W'(mtlb_pkg::SCAN_SLOTS));
   assign scan_idx   = scan_cnt_ff[mtlb_pkg::SLOT_W-1:0];

   // shared range compare; unwritten slots read as start 0, end 0
   assign rd_start = rd_vld_ff ? rd_data_ff[63:32] : 32'd0;
   assign rd_end   = rd_vld_ff ? rd_data_ff[31:0]  : 32'd0;
   assign slot_hit = (addr_ff >= rd_start) && (addr_ff <= rd_end);

   always_ff @(posedge clock) begin
      if (accept && req.opcode == mtlb_pkg::OP_WRITE_RANGE) begin
         range_mem[req.range_slot] <= {req.range_low, req.range_high};
      end
      if (scan_issue) begin
         rd_data_ff <= range_mem[scan_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_vld_ff <= '0;
         rd_vld_ff    <= 1'b0;
      end else begin
         if (accept && req.opcode == mtlb_pkg::OP_WRITE_RANGE) begin
            range_vld_ff[req.range_slot] <= 1'b1;
         end
         if (scan_issue) begin
            rd_vld_ff <= range_vld_ff[scan_idx];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      status_in    = status_ff;
      cause_in     = cause_ff;
      epc_in       = epc_ff;
      badv_in      = badv_ff;
      ctx_in       = ctx_ff;
      ehi_in       = ehi_ff;
      addr_in      = addr_ff;
      took_in      = took_ff;
      npc_in       = npc_ff;
      scan_cnt_in  = scan_cnt_ff;
      issue_in     = 1'b0;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_data_in  = rsp_data_ff;
      epc_base     = exl ? epc_ff : req.current_pc;
      epc_dec      = 32'd0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               addr_in     = req.fault_address;
               took_in     = 1'b0;
               npc_in      = 32'd0;
               hit_in      = 1'b0;
               scan_cnt_in = '0;
               state_in    = ST_DONE;
               case (req.opcode)
                  mtlb_pkg::OP_REFILL_LOAD, mtlb_pkg::OP_REFILL_STORE,
                  mtlb_pkg::OP_REFILL_FETCH: begin
                     took_in  = 1'b1;
                     badv_in  = req.fault_address;
                     ctx_in   = (ctx_ff & mtlb_pkg::CTX_KEEP_MASK) |
                                ((req.fault_address >> 9) & mtlb_pkg::CTX_VPN_MASK);
                     ehi_in   = req.fault_address & mtlb_pkg::EHI_VPN_MASK;
                     cause_in = (req.opcode == mtlb_pkg::OP_REFILL_STORE) ?
                                mtlb_pkg::CAUSE_TLB_STOR : mtlb_pkg::CAUSE_TLB_LOAD;
                     cause_in[31] = req.in_delay_slot;
                     status_in    = status_ff | mtlb_pkg::STATUS_EXL;
                     epc_dec = (req.in_delay_slot ? 32'd4 : 32'd0) +
                               ((req.opcode == mtlb_pkg::OP_REFILL_FETCH) ? 32'd0 : 32'd4);
                     epc_in  = epc_base - epc_dec;
                     if (exl || kseg0) begin
                        npc_in = mtlb_pkg::VEC_GENERAL;
                     end else begin
                        npc_in   = mtlb_pkg::VEC_REFILL;
                        state_in = ST_SCAN;
                     end
                  end
                  mtlb_pkg::OP_GENERAL: begin
                     took_in      = 1'b1;
                     npc_in       = mtlb_pkg::VEC_GENERAL;
                     status_in    = status_ff | mtlb_pkg::STATUS_EXL;
                     cause_in[31] = req.in_delay_slot;
                     epc_in = req.current_pc - (req.in_delay_slot ? 32'd4 : 32'd0);
                  end
                  mtlb_pkg::OP_WRITE_REG: begin
                     case (req.reg_select)
                        mtlb_pkg::SEL_STATUS:    status_in = req.reg_value;
                        mtlb_pkg::SEL_CAUSE:     cause_in  = req.reg_value;
                        mtlb_pkg::SEL_EPC:       epc_in    = req.reg_value;
                        mtlb_pkg::SEL_BAD_VADDR: badv_in   = req.reg_value;
                        mtlb_pkg::SEL_CONTEXT:   ctx_in    = req.reg_value;
                        mtlb_pkg::SEL_ENTRY_HI:  ehi_in    = req.reg_value;
                        default: ;
                     endcase
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_issue) begin
               issue_in    = 1'b1;
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end
            if (issue_ff && slot_hit) begin
               hit_in = 1'b1;
            end
            if (!scan_issue && !issue_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_data_in.took_exception = took_ff;
            rsp_data_in.next_pc        = hit_ff ? mtlb_pkg::VEC_GENERAL : npc_ff;
            rsp_data_in.status_out     = status_ff;
            rsp_data_in.cause_out      = cause_ff;
            rsp_data_in.epc_out        = epc_ff;
            rsp_data_in.bad_vaddr_out  = badv_ff;
            rsp_data_in.context_out    = ctx_ff;
            rsp_data_in.entry_hi_out   = ehi_ff;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         status_ff    <= '0;
         cause_ff     <= '0;
         epc_ff       <= '0;
         badv_ff      <= '0;
         ctx_ff       <= '0;
         ehi_ff       <= '0;
         scan_cnt_ff  <= '0;
         issue_ff     <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         cause_ff     <= cause_in;
         epc_ff       <= epc_in;
         badv_ff      <= badv_in;
         ctx_ff       <= ctx_in;
         ehi_ff       <= ehi_in;
         scan_cnt_ff  <= scan_cnt_in;
         issue_ff     <= issue_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      took_ff     <= took_in;
      npc_ff      <= npc_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> rtl/mtlb_chk.sv
// ----------------------------------------------------------------------------
// mtlb_chk: port-level checks
// Checks request/response sequencing and response contents at the ports.
// ----------------------------------------------------------------------------
module mtlb_chk (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input mtlb_pkg::rsp_type rsp_payload
);

   // one request in flight: no new request right after one is taken
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

   // one response per request
   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> !rsp_valid)
      else $error("response repeated");

   a_no_vec_on_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.took_exception) |-> rsp_payload.next_pc == 32'd0)
      else $error("vector without exception");

   a_exl_on_exc: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.took_exception) |->
         (rsp_payload.status_out & mtlb_pkg::STATUS_EXL) != 32'd0)
      else $error("exception without EXL");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled response changed");

endmodule

bind mips_tlb_refill_exception_entry mtlb_chk u_mtlb_chk (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_payload (rsp_if.payload)
);

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the CP0 TLB refill exception entry block
// Drives refills, general exceptions, range-table and register writes over
// the request channel with random gaps, predicts every response from a
// local copy of the CP0 registers and range table, and checks each response
// field by field as it is taken under random back-pressure.
// ----------------------------------------------------------------------------
module tb_top;

   localparam logic [31:0] CAUSE_BD  = 32'h8000_0000;
   localparam logic [31:0] EPC_STEP  = 32'd4;
   localparam int          RANDOM_REQUESTS = 800;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mtlb_req_if req_ch ();
   mtlb_rsp_if rsp_ch ();

   mips_tlb_refill_exception_entry u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predicted CP0 state
   bit [31:0] cp0_status, cp0_cause, cp0_epc, cp0_bad_vaddr, cp0_context, cp0_entry_hi;
   bit [31:0] map_lo [mtlb_pkg::RANGE_SLOTS];
   bit [31:0] map_hi [mtlb_pkg::RANGE_SLOTS];

   mtlb_pkg::rsp_type pending_responses [$];
   int      error_count;
   int      counted_requests;
   bit      req_held;
   bit      req_steady;
   bit      rsp_steady;

   function automatic int draw_req_gap();
      if ($urandom_range(0, 39) == 0) req_steady = !req_steady;
      return req_steady ? 0 : $urandom_range(0, 17);
   endfunction

   function automatic int draw_rsp_stall();
      if ($urandom_range(0, 39) == 0) rsp_steady = !rsp_steady;
      return rsp_steady ? 0 : $urandom_range(0, 17);
   endfunction

   function automatic bit addr_in_map(bit [31:0] a);
      for (int s = 0; s < mtlb_pkg::SCAN_SLOTS; s++)
         if (a >= map_lo[s] && a <= map_hi[s]) return 1'b1;
      return 1'b0;
   endfunction

   function automatic void mark_branch_delay(bit ds);
      if (ds) begin
         cp0_cause = cp0_cause | CAUSE_BD;
         cp0_epc   = cp0_epc - EPC_STEP;
      end else begin
         cp0_cause = cp0_cause & ~CAUSE_BD;
      end
   endfunction

   function automatic mtlb_pkg::rsp_type predict_response(mtlb_pkg::req_type r);
      mtlb_pkg::rsp_type p;
      bit [31:0] addr;
      addr             = r.fault_address;
      p.took_exception = 1'b0;
      p.next_pc        = '0;
      case (r.opcode)
         mtlb_pkg::OP_REFILL_LOAD, mtlb_pkg::OP_REFILL_STORE,
         mtlb_pkg::OP_REFILL_FETCH: begin
            cp0_cause     = (r.opcode == mtlb_pkg::OP_REFILL_STORE) ?
                            mtlb_pkg::CAUSE_TLB_STOR : mtlb_pkg::CAUSE_TLB_LOAD;
            cp0_bad_vaddr = addr;
            cp0_context   = (cp0_context & mtlb_pkg::CTX_KEEP_MASK) |
                            ((addr >> 9) & mtlb_pkg::CTX_VPN_MASK);
            cp0_entry_hi  = addr & mtlb_pkg::EHI_VPN_MASK;
            if ((cp0_status & mtlb_pkg::STATUS_EXL) != 0) begin
               p.next_pc = mtlb_pkg::VEC_GENERAL;
            end else begin
               cp0_epc    = r.current_pc;
               cp0_cause  = cp0_cause & ~CAUSE_BD;
               cp0_status = cp0_status | mtlb_pkg::STATUS_EXL;
               p.next_pc  = (addr[31:30] == mtlb_pkg::KSEG0_TOP || addr_in_map(addr)) ?
                            mtlb_pkg::VEC_GENERAL : mtlb_pkg::VEC_REFILL;
            end
            mark_branch_delay(r.in_delay_slot);
            if (r.opcode != mtlb_pkg::OP_REFILL_FETCH) cp0_epc = cp0_epc - EPC_STEP;
            p.took_exception = 1'b1;
         end
         mtlb_pkg::OP_GENERAL: begin
            cp0_status = cp0_status | mtlb_pkg::STATUS_EXL;
            cp0_epc    = r.current_pc;
            mark_branch_delay(r.in_delay_slot);
            p.next_pc        = mtlb_pkg::VEC_GENERAL;
            p.took_exception = 1'b1;
         end
         mtlb_pkg::OP_WRITE_RANGE: begin
            map_lo[r.range_slot] = r.range_low;
            map_hi[r.range_slot] = r.range_high;
         end
         mtlb_pkg::OP_WRITE_REG: begin
            case (r.reg_select)
               mtlb_pkg::SEL_STATUS:    cp0_status    = r.reg_value;
               mtlb_pkg::SEL_CAUSE:     cp0_cause     = r.reg_value;
               mtlb_pkg::SEL_EPC:       cp0_epc       = r.reg_value;
               mtlb_pkg::SEL_BAD_VADDR: cp0_bad_vaddr = r.reg_value;
               mtlb_pkg::SEL_CONTEXT:   cp0_context   = r.reg_value;
               mtlb_pkg::SEL_ENTRY_HI:  cp0_entry_hi  = r.reg_value;
               default: ;
            endcase
         end
         default: ;
      endcase
      p.status_out    = cp0_status;
      p.cause_out     = cp0_cause;
      p.epc_out       = cp0_epc;
      p.bad_vaddr_out = cp0_bad_vaddr;
      p.context_out   = cp0_context;
      p.entry_hi_out  = cp0_entry_hi;
      return p;
   endfunction

   function automatic mtlb_pkg::req_type noise_request();
      mtlb_pkg::req_type r;
      r.opcode        = 3'($urandom_range(0, 7));
      r.fault_address = $urandom;
      r.current_pc    = $urandom;
      r.in_delay_slot = 1'($urandom_range(0, 1));
      r.range_slot    = 6'($urandom_range(0, 63));
      r.range_low     = $urandom;
      r.range_high    = $urandom;
      r.reg_select    = 3'($urandom_range(0, 7));
      r.reg_value     = $urandom;
      return r;
   endfunction

   function automatic mtlb_pkg::req_type exception_req(logic [2:0] op, logic [31:0] addr,
                                                       logic [31:0] pc, logic ds);
      mtlb_pkg::req_type r;
      r               = noise_request();
      r.opcode        = op;
      r.fault_address = addr;
      r.current_pc    = pc;
      r.in_delay_slot = ds;
      return r;
   endfunction

   function automatic mtlb_pkg::req_type range_req(logic [5:0] slot, logic [31:0] lo,
                                                   logic [31:0] hi);
      mtlb_pkg::req_type r;
      r            = noise_request();
      r.opcode     = mtlb_pkg::OP_WRITE_RANGE;
      r.range_slot = slot;
      r.range_low  = lo;
      r.range_high = hi;
      return r;
   endfunction

   function automatic mtlb_pkg::req_type reg_req(logic [2:0] sel, logic [31:0] val);
      mtlb_pkg::req_type r;
      r            = noise_request();
      r.opcode     = mtlb_pkg::OP_WRITE_REG;
      r.reg_select = sel;
      r.reg_value  = val;
      return r;
   endfunction

   function automatic mtlb_pkg::req_type random_range_req();
      bit [31:0] lo, hi;
      lo = $urandom;
      case ($urandom_range(0, 3))
         0: hi = $urandom;
         1: hi = lo - $urandom_range(1, 4096);
         default: begin
            hi = lo + $urandom_range(0, 65535);
            if (hi < lo) hi = 32'hFFFF_FFFF;
         end
      endcase
      return range_req(6'($urandom_range(0, 63)), lo, hi);
   endfunction

   function automatic bit [31:0] pick_fault_address();
      bit [31:0] lo, hi;
      bit [5:0]  s;
      s  = 6'($urandom_range(0, 63));
      lo = map_lo[s];
      hi = map_hi[s];
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return {mtlb_pkg::KSEG0_TOP, 30'($urandom)};
         2: begin
            if (lo > hi) return lo;
            if (hi - lo == 32'hFFFF_FFFF) return $urandom;
            return lo + ($urandom % (hi - lo + 32'd1));
         end
         default: return $urandom_range(0, 1) ? hi + 32'd1 : lo - 32'd1;
      endcase
   endfunction

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         error_count++;
         if (error_count <= 10)
            $display("mismatch on %s: expected %h, actual %h", name, want, got);
      end
   endfunction

   task automatic check_response(mtlb_pkg::rsp_type got);
      mtlb_pkg::rsp_type want;
      if (pending_responses.size() == 0) begin
         error_count++;
         if (error_count <= 10) $display("response with no request outstanding: %h", got);
         return;
      end
      want = pending_responses.pop_front();
      compare_field("took_exception", 32'(want.took_exception), 32'(got.took_exception));
      compare_field("next_pc",        want.next_pc,        got.next_pc);
      compare_field("status_out",     want.status_out,     got.status_out);
      compare_field("cause_out",      want.cause_out,      got.cause_out);
      compare_field("epc_out",        want.epc_out,        got.epc_out);
      compare_field("bad_vaddr_out",  want.bad_vaddr_out,  got.bad_vaddr_out);
      compare_field("context_out",    want.context_out,    got.context_out);
      compare_field("entry_hi_out",   want.entry_hi_out,   got.entry_hi_out);
   endtask

   // called at a rising edge; valid stays up when the next gap is zero
   task automatic send_request(mtlb_pkg::req_type r);
      int gap;
      req_ch.payload <= r;
      req_ch.valid   <= 1'b1;
      req_held = 1'b1;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      pending_responses.push_back(predict_response(r));
      if (r.opcode <= mtlb_pkg::OP_WRITE_REG) counted_requests++;
      gap = draw_req_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         req_held = 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic release_request();
      if (req_held) begin
         req_ch.valid <= 1'b0;
         req_held = 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      release_request();
      while (pending_responses.size() != 0) @(posedge clock);
   endtask

   task automatic test_refill_vectors();
      send_request(exception_req(mtlb_pkg::OP_REFILL_LOAD, 32'h0000_0000, 32'h0000_0100,
                                 1'b0));
      send_request(reg_req(mtlb_pkg::SEL_STATUS, 32'h0000_0000));
      send_request(exception_req(mtlb_pkg::OP_REFILL_STORE, 32'hFFFF_FFFF, 32'h0000_0000,
                                 1'b1));
      // EXL still set: nested refill takes EPC from the old EPC, not the PC, and takes the general vector
      send_request(exception_req(mtlb_pkg::OP_REFILL_FETCH, 32'h8000_0000, 32'h0000_1234,
                                 1'b1));
      send_request(reg_req(mtlb_pkg::SEL_STATUS, 32'h0000_0000));
      send_request(exception_req(mtlb_pkg::OP_REFILL_FETCH, 32'h8000_0000, 32'hFFFF_FFFF,
                                 1'b0));
      send_request(reg_req(mtlb_pkg::SEL_STATUS, 32'h0000_0000));
      send_request(exception_req(mtlb_pkg::OP_REFILL_LOAD, 32'hBFFF_FFFF, 32'h0000_0004,
                                 1'b1));
      send_request(reg_req(mtlb_pkg::SEL_STATUS, 32'h0000_0000));
      send_request(exception_req(mtlb_pkg::OP_REFILL_LOAD, 32'hC000_0000, 32'h8000_0000,
                                 1'b0));
   endtask

   task automatic test_general_exception();
      send_request(exception_req(mtlb_pkg::OP_GENERAL, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1));
   endtask

   task automatic test_range_table();
      send_request(range_req(6'd5, 32'h0000_2000, 32'h0000_1000));
      send_request(reg_req(mtlb_pkg::SEL_STATUS, 32'h0000_0000));
      send_request(exception_req(mtlb_pkg::OP_REFILL_STORE, 32'h0000_1800, 32'h0000_0040,
                                 1'b0));
      send_request(range_req(6'd63, 32'h0040_0000, 32'h0040_1FFF));
      send_request(reg_req(mtlb_pkg::SEL_STATUS, 32'h0000_0000));
      send_request(exception_req(mtlb_pkg::OP_REFILL_LOAD, 32'h0040_1FFF, 32'h0000_0080,
                                 1'b0));
   endtask

   task automatic test_register_writes();
      for (int s = 0; s < 8; s++) send_request(reg_req(3'(s), 32'hFFFF_FFFF));
      send_request(exception_req(3'd6, $urandom, $urandom, 1'b1));
      send_request(exception_req(3'd7, $urandom, $urandom, 1'b0));
   endtask

   task automatic test_random_traffic();
      bit        paused;
      bit [31:0] val;
      logic [2:0] op;
      paused = 1'b0;
      while (counted_requests < RANDOM_REQUESTS) begin
         if (!paused && counted_requests >= RANDOM_REQUESTS / 2) begin
            wait_for_drain();
            paused = 1'b1;
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               if ($urandom_range(0, 1)) send_request(random_range_req());
               if ($urandom_range(0, 3) == 0)
                  send_request(reg_req(mtlb_pkg::SEL_CONTEXT, $urandom));
               val = $urandom;
               if ($urandom_range(0, 4) != 0) val = val & ~mtlb_pkg::STATUS_EXL;
               send_request(reg_req(mtlb_pkg::SEL_STATUS, val));
               op = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 2))
                                                : mtlb_pkg::OP_GENERAL;
               send_request(exception_req(op, pick_fault_address(), $urandom,
                                          1'($urandom_range(0, 1))));
            end
            6, 7: send_request(reg_req(3'($urandom_range(0, 7)), $urandom));
            8: send_request(noise_request());
            default: send_request(random_range_req());
         endcase
      end
   endtask

   initial begin
      int      stall;
      mtlb_pkg::rsp_type got;
      rsp_ch.ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = draw_rsp_stall();
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         got = rsp_ch.payload;
         check_response(got);
      end
   end

   initial begin
      #4_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_refill_vectors();
      test_general_exception();
      test_range_table();
      test_register_writes();
      wait_for_drain();
      counted_requests = 0;
      test_random_traffic();
      wait_for_drain();
      repeat (80) @(posedge clock);
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
